// ===== rtl/pulse_rate_meter_with_alarm_assert.svh =====
// Assertion macros for the pulse rate meter checker.
`ifndef PULSE_RATE_METER_WITH_ALARM_ASSERT_SVH
`define PULSE_RATE_METER_WITH_ALARM_ASSERT_SVH

// Clocked assertion, masked while reset is held.
`define PRM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked assertion, checked in every cycle, reset included.
`define PRM_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/prm_pkg.sv =====
// Types and constants shared by the pulse rate meter files.
`default_nettype none
package prm_pkg;

  // Field and state widths
  localparam int PERIOD_W   = 13;
  localparam int RATE_W     = 16;
  localparam int CONF_W     = 3;
  localparam int LIMIT_W    = 8;
  localparam int CFG_ADDR_W = 8;
  localparam int DIV_CNT_W  = $clog2(RATE_W);

  // Register map
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LIMIT = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT  = CFG_ADDR_W'(1);

  // Register reset values
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = LIMIT_W'(100);
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = LIMIT_W'(40);

  // Result kinds
  localparam logic EV_RATE    = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// ===== rtl/prm_if.sv =====
// Handshake channel interfaces of the pulse rate meter.
`default_nettype none

// Input word channel
interface prm_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic sample_strobe;
  logic pulse_level;
  modport source (output valid, ms_tick, sample_strobe, pulse_level, input ready);
  modport sink   (input valid, ms_tick, sample_strobe, pulse_level, output ready);
endinterface

// Result word channel
interface prm_out_if;
  import prm_pkg::*;
  logic              valid;
  logic              ready;
  logic              event_kind;
  logic [RATE_W-1:0] beats_per_minute;
  logic              alarm;
  modport source (output valid, event_kind, beats_per_minute, alarm, input ready);
  modport sink   (input valid, event_kind, beats_per_minute, alarm, output ready);
endinterface

// Register write channel
interface prm_cfg_if;
  import prm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [LIMIT_W-1:0]    data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/prm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module prm_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire prm_pkg::div_ctl_t   ctl,
  input  wire [prm_pkg::RATE_W-1:0]   dividend,
  input  wire [prm_pkg::PERIOD_W-1:0] divisor,
  output prm_pkg::div_sts_t        sts,
  output logic [prm_pkg::RATE_W-1:0]  quotient
);
  import prm_pkg::*;

  logic [PERIOD_W-1:0]  rem_r, rem_nxt;
  logic [RATE_W-1:0]    dvd_r, dvd_nxt;
  logic [RATE_W-1:0]    quo_r, quo_nxt;
  logic [PERIOD_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 ge;

  // Trial subtract of the shifted partial remainder
  assign trial = {rem_r, dvd_r[RATE_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      dvd_nxt = {dvd_r[RATE_W-2:0], 1'b0};
      quo_nxt = {quo_r[RATE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(RATE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/pulse_rate_meter_with_alarm.sv =====
// Pulse rate meter top level: beat detection, period count, rate and alarm.
// A word without a measured beat (tick only, plain sample, or a timeout) is
// taken without leaving the idle state; a timeout result is loaded into the
// output register in the cycle that accepts the word. A word that closes a
// measured period starts the serial divider, which yields one quotient bit
// per cycle; with a 16-bit numerator the word passes through accept, 16
// divider steps, hand-off and limit compare before the next word is taken;
// a word is accepted only while the output register is empty or being read.
// Limits may be written at any time the block is idle; cfg_ch.ready is
// always high and writes to addresses above the register map are dropped.
`default_nettype none
module pulse_rate_meter_with_alarm #(
  parameter int TIMEOUT_TICKS   = 5000,
  parameter int RATE_NUMERATOR  = 60000,
  parameter int CONFIRM_SAMPLES = 4
) (
  input wire        clk,
  input wire        rst_n,
  prm_in_if.sink    in_ch,
  prm_out_if.source out_ch,
  prm_cfg_if.sink   cfg_ch
);
  import prm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic                armed_r, armed_nxt;
  logic [CONF_W-1:0]   conf_r, conf_nxt;
  logic                alarm_r, alarm_nxt;
  logic [LIMIT_W-1:0]  high_r, low_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [RATE_W-1:0]   out_bpm_r, out_bpm_nxt;
  logic                out_alarm_r, out_alarm_nxt;

  logic                in_acc;
  logic [PERIOD_W-1:0] cnt_tick;
  logic                timeout;
  logic [PERIOD_W-1:0] cnt_a;
  logic                armed_a;
  logic                alarm_a;
  logic                beat;
  logic [PERIOD_W-1:0] divisor;
  logic                rate_alarm;

  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [RATE_W-1:0]   quotient;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Millisecond tick and timeout
  assign cnt_tick = in_ch.ms_tick ? cnt_r + 1'b1 : cnt_r;
  assign timeout  = in_ch.ms_tick && (cnt_tick == PERIOD_W'(TIMEOUT_TICKS));
  assign cnt_a    = timeout ? '0 : cnt_tick;
  assign armed_a  = timeout ? 1'b0 : armed_r;
  assign alarm_a  = timeout ? 1'b0 : alarm_r;

  // Beat confirmation sequence
  always_comb begin
    conf_nxt = conf_r;
    beat     = 1'b0;
    if (in_ch.sample_strobe) begin
      if (conf_r < CONF_W'(CONFIRM_SAMPLES)) begin
        conf_nxt = in_ch.pulse_level ? '0 : conf_r + 1'b1;
      end else if (in_ch.pulse_level) begin
        beat     = 1'b1;
        conf_nxt = '0;
      end
    end
  end

  // Zero period divides as one
  assign divisor    = (cnt_a == '0) ? PERIOD_W'(1) : cnt_a;
  assign rate_alarm = (quotient >= RATE_W'(high_r)) || (quotient <= RATE_W'(low_r));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    armed_nxt     = armed_r;
    alarm_nxt     = alarm_r;
    div_ctl.start = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_bpm_nxt   = out_bpm_r;
    out_alarm_nxt = out_alarm_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = cnt_a;
          armed_nxt = armed_a;
          alarm_nxt = alarm_a;
          if (timeout) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = EV_TIMEOUT;
            out_bpm_nxt   = '0;
            out_alarm_nxt = 1'b0;
          end
          if (beat) begin
            cnt_nxt = '0;
            if (armed_a) begin
              armed_nxt     = 1'b0;
              div_ctl.start = 1'b1;
              state_nxt     = ST_DIV;
            end else begin
              armed_nxt = 1'b1;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        alarm_nxt     = rate_alarm;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = EV_RATE;
        out_bpm_nxt   = quotient;
        out_alarm_nxt = rate_alarm;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      armed_r     <= 1'b0;
      conf_r      <= '0;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      armed_r     <= armed_nxt;
      alarm_r     <= alarm_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        conf_r <= conf_nxt;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_bpm_r   <= out_bpm_nxt;
    out_alarm_r <= out_alarm_nxt;
  end

  // Limit registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= HIGH_LIMIT_RST;
      low_r  <= LOW_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.addr == CFG_HIGH_LIMIT) begin
        high_r <= cfg_ch.data;
      end else if (cfg_ch.addr == CFG_LOW_LIMIT) begin
        low_r <= cfg_ch.data;
      end
    end
  end

  // Serial divider
  prm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (RATE_W'(RATE_NUMERATOR)),
    .divisor  (divisor),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_kind       = out_kind_r;
  assign out_ch.beats_per_minute = out_bpm_r;
  assign out_ch.alarm            = out_alarm_r;

endmodule
`default_nettype wire

// ===== rtl/prm_checker.sv =====
// Port-level checker for the pulse rate meter, bound to the top level.
`default_nettype none
`include "pulse_rate_meter_with_alarm_assert.svh"
module prm_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        in_ms_tick,
  input wire                        in_sample_strobe,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire                        out_event_kind,
  input wire [prm_pkg::RATE_W-1:0]  out_beats_per_minute,
  input wire                        out_alarm
);
  import prm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A timeout word carries no rate and no alarm
  `PRM_ASSERT(a_timeout_clean, clk, rst_n, (out_valid && out_event_kind == EV_TIMEOUT) |-> (out_beats_per_minute == '0 && !out_alarm), "timeout result with rate or alarm set")

  // A word with neither tick nor sample never yields a result
  `PRM_ASSERT(a_idle_word_quiet, clk, rst_n, (in_acc && !in_ms_tick && !in_sample_strobe) |=> !out_valid, "result from a word with no tick and no sample")

  // A rate result needs the divider and never shows right after an accept
  `PRM_ASSERT(a_rate_latency, clk, rst_n, ($rose(out_valid) && out_event_kind == EV_RATE) |-> !$past(in_acc), "rate result too early")

  // A stalled result word holds
  `PRM_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_event_kind) && $stable(out_beats_per_minute) && $stable(out_alarm)), "stalled result changed")

endmodule

bind pulse_rate_meter_with_alarm prm_checker u_prm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .in_ms_tick           (in_ch.ms_tick),
  .in_sample_strobe     (in_ch.sample_strobe),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_event_kind       (out_ch.event_kind),
  .out_beats_per_minute (out_ch.beats_per_minute),
  .out_alarm            (out_ch.alarm)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the pulse rate meter: directed rows, boundaries, timeouts, random.
`timescale 1ns / 1ps
module tb;
  import prm_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int TIMEOUT_TICKS   = 5000;
  localparam int RATE_NUMERATOR  = 60000;
  localparam int CONFIRM_SAMPLES = 4;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int LIMIT_CYCLES    = 6000000;
  localparam int MAX_REPORTS     = 10;

  // Addresses outside the register map; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] CFG_BEYOND_MAP = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_TOP   = '1;

  typedef struct packed {
    logic              kind;
    logic [RATE_W-1:0] bpm;
    logic              alarm;
  } rate_word_t;

  // One directed word; typed rows carry their result, the rest use the predictor
  typedef struct packed {
    logic       tick;
    logic       strobe;
    logic       level;
    logic       typed;
    logic       has;
    rate_word_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  prm_in_if  in_ch ();
  prm_out_if out_ch ();
  prm_cfg_if cfg_ch ();

  pulse_rate_meter_with_alarm #(
    .TIMEOUT_TICKS  (TIMEOUT_TICKS),
    .RATE_NUMERATOR (RATE_NUMERATOR),
    .CONFIRM_SAMPLES(CONFIRM_SAMPLES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state and limits
  logic [PERIOD_W-1:0] period_cnt;
  logic                meter_armed;
  logic [CONF_W-1:0]   confirm_cnt;
  logic                alarm_on;
  logic [LIMIT_W-1:0]  high_lim;
  logic [LIMIT_W-1:0]  low_lim;

  rate_word_t due_results[$];
  int         errors;
  int         words_sent;
  int         results_made;
  int         cycles;
  int         hold_req;
  int         hold_ack;
  bit         calm;
  bit         tx_quiet;
  int         tx_stretch;

  // After reset, then two beats with no ticks between (zero count taken as one),
  // then a tick riding on the arming beat and a five tick period
  stim_row_t dir_rows [25] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, '{EV_RATE, RATE_W'(60000), 1'b1}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '{EV_RATE, RATE_W'(0), 1'b0}},
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '{EV_RATE, RATE_W'(12000), 1'b1}}
  };

  // Meter response to one word: tick first, then the sample
  function automatic bit meter_step(input logic tick, input logic strobe, input logic level,
                                    output rate_word_t res);
    bit                got;
    bit                beat;
    int                divisor;
    logic [RATE_W-1:0] bpm;
    got  = 1'b0;
    beat = 1'b0;
    res  = '0;
    if (tick) begin
      period_cnt = period_cnt + 1'b1;
      if (period_cnt == TIMEOUT_TICKS) begin
        period_cnt  = '0;
        meter_armed = 1'b0;
        alarm_on    = 1'b0;
        res         = '{EV_TIMEOUT, RATE_W'(0), 1'b0};
        got         = 1'b1;
      end
    end
    // confirmation: low samples advance; in the last state only a high sample counts
    if (strobe) begin
      if (confirm_cnt < CONFIRM_SAMPLES) begin
        confirm_cnt = level ? '0 : confirm_cnt + 1'b1;
      end else if (level) begin
        beat        = 1'b1;
        confirm_cnt = '0;
      end
    end
    if (beat && meter_armed) begin
      divisor     = (period_cnt == 0) ? 1 : int'(period_cnt);
      bpm         = RATE_W'(RATE_NUMERATOR / divisor);
      alarm_on    = (bpm >= high_lim) || (bpm <= low_lim);
      period_cnt  = '0;
      meter_armed = 1'b0;
      // a timeout in the same word already took the one result slot
      if (!got) begin
        res = '{EV_RATE, bpm, alarm_on};
        got = 1'b1;
      end
    end else if (beat) begin
      period_cnt  = '0;
      meter_armed = 1'b1;
    end
    return got;
  endfunction

  function automatic void meter_write(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [LIMIT_W-1:0] data);
    if (addr == CFG_HIGH_LIMIT) high_lim = data;
    else if (addr == CFG_LOW_LIMIT) low_lim = data;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Present one word and wait for it to be taken; valid stays high afterwards
  task automatic offer_word(input logic tick, input logic strobe, input logic level);
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(10, 150);
      tx_quiet   = ($urandom_range(0, 3) == 0);
    end
    tx_stretch--;
    if (!calm && !tx_quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.ms_tick       <= tick;
    in_ch.sample_strobe <= strobe;
    in_ch.pulse_level   <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_word(input logic tick, input logic strobe, input logic level);
    rate_word_t res;
    offer_word(tick, strobe, level);
    if (meter_step(tick, strobe, level, res)) begin
      due_results.push_back(res);
      results_made++;
    end
    if (tick || strobe) words_sent++;
  endtask

  // Lows then one high sample, with exactly `ticks` ticks before the high one
  task automatic drive_pulse(input int ticks, input int lows);
    int   t_left;
    int   s_left;
    logic tk;
    t_left = ticks;
    s_left = lows + 1;
    while (t_left > 0 || s_left > 1) begin
      if (s_left > 1 && $urandom_range(1, t_left + s_left - 1) <= s_left - 1) begin
        tk = (t_left > 0) ? logic'($urandom_range(0, 1)) : 1'b0;
        send_word(tk, 1'b1, 1'b0);
        if (tk) t_left--;
        s_left--;
      end else begin
        send_word(1'b1, 1'b0, logic'($urandom_range(0, 1)));
        t_left--;
      end
    end
    send_word(1'b0, 1'b1, 1'b1);
  endtask

  // Arm on a zero count, then close a period of exactly n ticks
  task automatic measure_period(input int n);
    if (meter_armed) drive_pulse(0, CONFIRM_SAMPLES);
    drive_pulse(0, CONFIRM_SAMPLES);
    drive_pulse(n, CONFIRM_SAMPLES);
  endtask

  // Wait until every due result is in and the block has had time to go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [LIMIT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    meter_write(addr, data);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] hi, input logic [LIMIT_W-1:0] lo,
                            input bit stray);
    settle();
    cfg_write(CFG_HIGH_LIMIT, hi);
    if (stray || $urandom_range(0, 1)) cfg_write(CFG_BEYOND_MAP, LIMIT_W'($urandom));
    cfg_write(CFG_LOW_LIMIT, lo);
    if (stray || $urandom_range(0, 1)) cfg_write(CFG_ADDR_TOP, LIMIT_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly short periods, now and then a long one up to just under the timeout
  function automatic int pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 40);
    if (r < 90) return $urandom_range(41, 300);
    if (r < 98) return $urandom_range(301, 1000);
    return $urandom_range(1001, TIMEOUT_TICKS - 1);
  endfunction

  // Mostly clean pulses, some broken sequences and raw noise
  task automatic run_random(input int words_goal, input int results_goal);
    int w0;
    int r0;
    int pick;
    w0 = words_sent;
    r0 = results_made;
    while (words_sent - w0 < words_goal || results_made - r0 < results_goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        drive_pulse(meter_armed ? pick_period() : $urandom_range(0, 3),
                    $urandom_range(CONFIRM_SAMPLES, 7));
      end else if (pick < 17) begin
        drive_pulse($urandom_range(0, 20), $urandom_range(0, CONFIRM_SAMPLES - 1));
      end else begin
        repeat ($urandom_range(1, 8))
          send_word(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                    logic'($urandom_range(0, 1)));
      end
    end
  endtask

  // Timeout on the word that also completes a beat, then one with the alarm up
  task automatic run_timeouts();
    while (confirm_cnt < CONFIRM_SAMPLES) send_word(1'b0, 1'b1, 1'b0);
    while (period_cnt != TIMEOUT_TICKS - 1) send_word(1'b1, 1'b0, logic'($urandom_range(0, 1)));
    send_word(1'b1, 1'b1, 1'b1);
    drive_pulse(0, CONFIRM_SAMPLES);
    drive_pulse(0, CONFIRM_SAMPLES);
    repeat (TIMEOUT_TICKS) send_word(1'b1, 1'b0, logic'($urandom_range(0, 1)));
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result sink: checks each word, then drives ready with stalls and hold-offs
  initial begin
    rate_word_t want;
    int         idle_left;
    int         hold_left;
    int         rx_stretch;
    bit         rx_quiet;
    int         rx_count;
    idle_left  = 0;
    hold_left  = 0;
    rx_stretch = 0;
    rx_quiet   = 1'b0;
    rx_count   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          note_error($sformatf("word %0d with none due: kind %0d bpm %0d alarm %0d", rx_count,
                               out_ch.event_kind, out_ch.beats_per_minute, out_ch.alarm));
        end else begin
          want = due_results.pop_front();
          if (out_ch.event_kind !== want.kind || out_ch.beats_per_minute !== want.bpm ||
              out_ch.alarm !== want.alarm)
            note_error($sformatf("word %0d: expected kind %0d bpm %0d alarm %0d, got %0d %0d %0d",
                                 rx_count, want.kind, want.bpm, want.alarm, out_ch.event_kind,
                                 out_ch.beats_per_minute, out_ch.alarm));
        end
        rx_count++;
      end
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(20, 200);
        rx_quiet   = ($urandom_range(0, 3) == 0);
      end
      rx_stretch--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && !rx_quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    rate_word_t res;
    bit         got;
    errors       = 0;
    words_sent   = 0;
    results_made = 0;
    cycles       = 0;
    hold_req     = 0;
    hold_ack     = 0;
    calm         = 1'b0;
    tx_quiet     = 1'b0;
    tx_stretch   = 0;
    period_cnt   = '0;
    meter_armed  = 1'b0;
    confirm_cnt  = '0;
    alarm_on     = 1'b0;
    high_lim     = HIGH_LIMIT_RST;
    low_lim      = LOW_LIMIT_RST;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.ms_tick       <= 1'b0;
    in_ch.sample_strobe <= 1'b0;
    in_ch.pulse_level   <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.addr         <= '0;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows on the reset limits
    foreach (dir_rows[i]) begin
      offer_word(dir_rows[i].tick, dir_rows[i].strobe, dir_rows[i].level);
      got = meter_step(dir_rows[i].tick, dir_rows[i].strobe, dir_rows[i].level, res);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has) due_results.push_back(dir_rows[i].res);
      end else if (got) begin
        due_results.push_back(res);
      end
    end

    // Rates on and next to both limits, and the longest period
    set_limits(LIMIT_W'(100), LIMIT_W'(40), 1'b1);
    measure_period(600);
    measure_period(601);
    measure_period(1463);
    measure_period(1500);
    measure_period(TIMEOUT_TICKS - 1);

    set_limits('1, '0, 1'b0);
    run_random(475, 12);

    // Receiver holds off while the sender keeps pushing zero-count beats
    set_limits('0, '1, 1'b0);
    hold_req++;
    repeat (6) drive_pulse(0, CONFIRM_SAMPLES);
    run_random(475, 12);

    set_limits(LIMIT_W'(200), LIMIT_W'(60), 1'b0);
    run_random(475, 12);

    set_limits(LIMIT_W'($urandom), LIMIT_W'($urandom), 1'b0);
    run_timeouts();

    // Closing stretch with both sides always ready
    set_limits(LIMIT_W'($urandom), LIMIT_W'($urandom), 1'b0);
    calm = 1'b1;
    run_random(475, 12);
    settle();

    if (errors == 0 && due_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/prm_pkg.sv
rtl/prm_if.sv
rtl/prm_div.sv
rtl/pulse_rate_meter_with_alarm.sv
rtl/prm_checker.sv
test/tb.sv
